// ----- hw/rtl/cfs_pkg.sv -----
// Package: modes, event codes, register map and shared types of the failsafe supervisor.
`timescale 1ns / 1ps

package cfs_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_DEGRADED = 2'd1,
        MODE_ALERT    = 2'd2,
        MODE_RECOVERY = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_LOST        = 3'd1,
        EV_RESTORED    = 3'd2,
        EV_ALERT       = 3'd3,
        EV_FROM_ALERT  = 3'd4,
        EV_INTERRUPTED = 3'd5,
        EV_NORMAL      = 3'd6
    } event_t;

    localparam int unsigned ADDR_W = 3;

    localparam logic REG_CRITICAL_TIMEOUT = 1'b0;
    localparam logic REG_RECOVERY_HOLD    = 1'b1;

    localparam logic [31:0] CRITICAL_TIMEOUT_RST = 32'd30000;
    localparam logic [31:0] RECOVERY_HOLD_RST    = 32'd5000;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    typedef struct packed {
        logic [31:0] critical_timeout_ms;
        logic [31:0] recovery_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic        wifi_up;
        logic        broker_up;
        logic        danger_seen;
        logic [31:0] now_ms;
    } update_t;

    typedef struct packed {
        mode_t  mode_now;
        logic   changed;
        event_t event_code;
    } result_t;

endpackage

// ----- hw/rtl/cfs_regs.sv -----
// APB configuration registers of the failsafe supervisor.
`timescale 1ns / 1ps

module cfs_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cfs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output cfs_pkg::cfg_t              cfg
);
    import cfs_pkg::*;

    logic [31:0] critical_timeout_reg;
    logic [31:0] recovery_hold_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            critical_timeout_reg <= CRITICAL_TIMEOUT_RST;
            recovery_hold_reg    <= RECOVERY_HOLD_RST;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_CRITICAL_TIMEOUT)
                critical_timeout_reg <= pwdata;
            else
                recovery_hold_reg <= pwdata;
        end
    end

    always_comb
    begin
        if (reg_sel == REG_CRITICAL_TIMEOUT)
            prdata = critical_timeout_reg;
        else
            prdata = recovery_hold_reg;
    end

    assign cfg.critical_timeout_ms = critical_timeout_reg;
    assign cfg.recovery_hold_ms    = recovery_hold_reg;

endmodule

// ----- hw/rtl/cfs_step.sv -----
// Mode state machine: supervisor state registers and the per-update transition logic.
`timescale 1ns / 1ps

module cfs_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  cfs_pkg::update_t upd,
    input  cfs_pkg::cfg_t    cfg,
    output cfs_pkg::result_t res
);
    import cfs_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [31:0] entry_time_reg, entry_time_next;
    logic        tracking_reg, tracking_next;
    logic [31:0] danger_start_reg, danger_start_next;
    event_t      ev;
    logic        linked;
    logic        danger_expired;
    logic        hold_done;
    logic [31:0] danger_elapsed;
    logic [31:0] entry_elapsed;

    assign linked         = upd.wifi_up && upd.broker_up;
    // wrapping differences, modulo 2^32
    assign danger_elapsed = upd.now_ms - danger_start_reg;
    assign entry_elapsed  = upd.now_ms - entry_time_reg;
    assign danger_expired = danger_elapsed >= cfg.critical_timeout_ms;
    assign hold_done      = entry_elapsed >= cfg.recovery_hold_ms;

    // next mode and event
    always_comb
    begin
        mode_next = mode_reg;
        ev        = EV_NONE;
        case (mode_reg)
            MODE_NORMAL:
            begin
                if (!linked)
                begin
                    mode_next = MODE_DEGRADED;
                    ev        = EV_LOST;
                end
            end
            MODE_DEGRADED:
            begin
                if (linked)
                begin
                    mode_next = MODE_RECOVERY;
                    ev        = EV_RESTORED;
                end
                else if (upd.danger_seen && tracking_reg && danger_expired)
                begin
                    mode_next = MODE_ALERT;
                    ev        = EV_ALERT;
                end
            end
            MODE_ALERT:
            begin
                if (linked)
                begin
                    mode_next = MODE_RECOVERY;
                    ev        = EV_FROM_ALERT;
                end
            end
            MODE_RECOVERY:
            begin
                if (!linked)
                begin
                    mode_next = MODE_DEGRADED;
                    ev        = EV_INTERRUPTED;
                end
                else if (hold_done)
                begin
                    mode_next = MODE_NORMAL;
                    ev        = EV_NORMAL;
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
                ev        = EV_NONE;
            end
        endcase
    end

    // entry time and danger tracking
    always_comb
    begin
        entry_time_next   = entry_time_reg;
        tracking_next     = tracking_reg;
        danger_start_next = danger_start_reg;
        if (ev != EV_NONE)
        begin
            entry_time_next = upd.now_ms;
            tracking_next   = 1'b0;
        end
        else if (mode_reg == MODE_NORMAL)
            tracking_next = 1'b0;
        else if (mode_reg == MODE_DEGRADED)
        begin
            if (!upd.danger_seen)
                tracking_next = 1'b0;
            else if (!tracking_reg)
            begin
                // onset only records the start; timeout is checked from the next update
                tracking_next     = 1'b1;
                danger_start_next = upd.now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_NORMAL;
            entry_time_reg   <= '0;
            tracking_reg     <= 1'b0;
            danger_start_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg         <= mode_next;
            entry_time_reg   <= entry_time_next;
            tracking_reg     <= tracking_next;
            danger_start_reg <= danger_start_next;
        end
    end

    assign res.mode_now   = mode_next;
    assign res.changed    = (ev != EV_NONE);
    assign res.event_code = ev;

endmodule

// ----- hw/rtl/connectivity_failsafe_fsm.sv -----
// Top level of the connectivity failsafe supervisor: stream stages, step logic, config port.
//
//  channel  | direction | transfer
//  ---------+-----------+-----------------------------------------------------------
//  s_axis   | in        | one update: wifi_up, broker_up, danger_seen, now_ms
//  m_axis   | out       | one result per update: mode_now, changed, event_code
//  apb      | in/out    | critical_timeout_ms at 0x0, recovery_hold_ms at 0x4
//
//  One update per clock sustained while m_tready stays high.
//  Updates pass an input register, the state machine step, then an output register.
//  The input stage reloads in the cycle its item moves on, so a stalled output only
//  holds the input register once the output register is full.
//  rst_n is asynchronous: mode normal, times zero, registers at their defaults.
`timescale 1ns / 1ps

module connectivity_failsafe_fsm (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [0] wifi_up, [1] broker_up, [2] danger_seen, [34:3] now_ms, [39:35] zero
    input  logic [39:0]                s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [1:0] mode_now, [2] changed, [5:3] event_code, [7:6] zero
    output logic [7:0]                 m_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cfs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import cfs_pkg::*;

    cfg_t    cfg;
    update_t in_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    result_t res;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.wifi_up     <= s_tdata[0];
            in_reg.broker_up   <= s_tdata[1];
            in_reg.danger_seen <= s_tdata[2];
            in_reg.now_ms      <= s_tdata[34:3];
        end
        if (advance)
            out_reg <= res;
    end

    cfs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cfs_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .upd     (in_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.event_code, out_reg.changed, out_reg.mode_now};

endmodule

// ----- hw/rtl/cfs_checker.sv -----
// Port-level checker for the failsafe supervisor, bound to the top level.
`timescale 1ns / 1ps

module cfs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import cfs_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // changed flag and event code agree
    a_changed_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2] == (m_tdata[5:3] != EV_NONE)))
        else $error("changed flag does not match event code");

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[5:3] != 3'd7))
        else $error("undefined event code");

    // each event lands in its target mode
    a_event_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            ((m_tdata[5:3] != EV_LOST && m_tdata[5:3] != EV_INTERRUPTED)
                || m_tdata[1:0] == MODE_DEGRADED)
            && (m_tdata[5:3] != EV_ALERT || m_tdata[1:0] == MODE_ALERT)
            && ((m_tdata[5:3] != EV_RESTORED && m_tdata[5:3] != EV_FROM_ALERT)
                || m_tdata[1:0] == MODE_RECOVERY)
            && (m_tdata[5:3] != EV_NORMAL || m_tdata[1:0] == MODE_NORMAL))
        else $error("event code and mode disagree");

endmodule

bind connectivity_failsafe_fsm cfs_checker u_cfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
